// ===== src/ucs_pkg.sv =====
// Shared types and constants of the character histogram.
`default_nettype none

package ucs_pkg;

  // Widths of the channel fields.
  localparam int CHAR_W  = 16;
  localparam int COUNT_W = 32;

  // Operation codes carried in the func field.
  localparam logic FUNC_COUNT  = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic              func;
    logic [CHAR_W-1:0] code;
  } op_t;

  // Status that the back reports to the front.
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

// ===== src/ucs_in_if.sv =====
// Input channel: valid/ready handshake carrying one count or report request.
`default_nettype none

interface ucs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [ucs_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output func, output char_code, input ready);
  modport sink   (input valid, input func, input char_code, output ready);
endinterface

`default_nettype wire

// ===== src/ucs_out_if.sv =====
// Output channel: valid/ready handshake carrying one report entry.
`default_nettype none

interface ucs_out_if;
  logic                       valid;
  logic                       ready;
  logic [ucs_pkg::CHAR_W-1:0]  entry_code;
  logic [ucs_pkg::COUNT_W-1:0] entry_count;
  logic                       last_entry;
  logic                       none_left;

  modport source (output valid, output entry_code, output entry_count,
                  output last_entry, output none_left, input ready);
  modport sink   (input valid, input entry_code, input entry_count,
                  input last_entry, input none_left, output ready);
endinterface

`default_nettype wire

// ===== src/ucs_fifo.sv =====
// Short operation queue between the front and the back.
`default_nettype none

module ucs_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  ucs_pkg::op_t push_data,
  input  logic         pop,
  output logic         full,
  output logic         not_empty,
  output ucs_pkg::op_t head
);

  ucs_pkg::op_t                   slots [ucs_pkg::QUEUE_DEPTH];
  logic [ucs_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ucs_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ucs_pkg::QPTR_W:0]       fill;

  assign full      = (fill == (ucs_pkg::QPTR_W + 1)'(ucs_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/ucs_front.sv =====
// Front end: takes requests, masks the code to the bin range and queues them.
`default_nettype none

module ucs_front #(
  parameter int CODE_BITS = 16
) (
  ucs_in_if.sink               items,
  input  ucs_pkg::back_status_t status,
  input  logic                 queue_full,
  output logic                 push,
  output ucs_pkg::op_t         push_data
);

  localparam logic [ucs_pkg::CHAR_W-1:0] CODE_MASK =
    ucs_pkg::CHAR_W'((1 << CODE_BITS) - 1);

  // Nothing is taken while the count store is being cleared.
  assign items.ready = !queue_full && !status.clearing;
  assign push        = items.valid && items.ready;

  always_comb begin
    push_data.func = items.func;
    // Report requests carry no code; a zero keeps the queue contents tidy.
    if (items.func == ucs_pkg::FUNC_COUNT) begin
      push_data.code = items.char_code & CODE_MASK;
    end else begin
      push_data.code = '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/ucs_back.sv =====
// Back end: count store, read-modify-write counting and the report scanner.
`default_nettype none

module ucs_back #(
  parameter int CODE_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  not_empty,
  input  ucs_pkg::op_t          head,
  output logic                  pop,
  output ucs_pkg::back_status_t status,
  ucs_out_if.source             results
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  localparam int NUM_BINS = 1 << CODE_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] mem [NUM_BINS];

  logic [1:0]            state;
  logic [CODE_BITS-1:0]  clr_idx;
  logic [CODE_BITS-1:0]  scan_cursor;
  logic [CODE_BITS:0]    distinct_left;
  logic [CODE_BITS:0]    distinct_left_next;

  // Count pipeline: stage B holds the address whose read data arrives now.
  logic                  b_valid;
  logic [CODE_BITS-1:0]  b_addr;
  logic                  fwd_valid;
  logic [CODE_BITS-1:0]  fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;

  // Scanner: chk_addr is the address whose read data arrives now.
  logic [CODE_BITS-1:0]  scan_pos;
  logic                  chk_valid;
  logic [CODE_BITS-1:0]  chk_addr;

  logic                  mem_we;
  logic [CODE_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [CODE_BITS-1:0]  mem_raddr;
  logic [COUNT_BITS-1:0] rd_data;

  logic                  out_valid;
  logic [CODE_BITS-1:0]  out_code;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_last;
  logic                  out_none;

  logic                  head_is_count;
  logic                  pop_count;
  logic                  pop_report;
  logic                  found;
  logic                  found_last;
  logic [COUNT_BITS-1:0] old_count;
  logic [COUNT_BITS-1:0] new_count;

  assign status.clearing = (state == ST_CLEAR);

  assign head_is_count = (head.func == ucs_pkg::FUNC_COUNT);
  // A report starts only when the count pipeline has drained, so that the
  // distinct count and the store are current, and the result slot is free.
  assign pop_count  = (state == ST_RUN) && not_empty && head_is_count;
  assign pop_report = (state == ST_RUN) && not_empty && !head_is_count &&
                      !b_valid && !out_valid;
  assign pop        = pop_count || pop_report;

  assign found      = (state == ST_SCAN) && chk_valid && (rd_data != '0);
  assign found_last = (distinct_left == (CODE_BITS + 1)'(1));

  // The write made in the previous cycle is not yet in the read data.
  assign old_count = (fwd_valid && (fwd_addr == b_addr)) ? fwd_data : rd_data;
  assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;

  always_comb begin
    mem_raddr = (state == ST_SCAN) ? scan_pos : head.code[CODE_BITS-1:0];
    mem_we    = 1'b0;
    mem_waddr = b_addr;
    mem_wdata = new_count;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (b_valid) begin
      mem_we = 1'b1;
    end else if (found) begin
      mem_we    = 1'b1;
      mem_waddr = chk_addr;
      mem_wdata = '0;
    end
  end

  always_comb begin
    distinct_left_next = distinct_left;
    if (b_valid && (old_count == '0)) begin
      distinct_left_next = distinct_left + 1'b1;
    end else if (found) begin
      distinct_left_next = distinct_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      scan_cursor   <= '0;
      distinct_left <= '0;
      b_valid       <= 1'b0;
      fwd_valid     <= 1'b0;
      chk_valid     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      distinct_left <= distinct_left_next;
      b_valid       <= pop_count;
      fwd_valid     <= mem_we;

      if (results.ready && out_valid) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (pop_report) begin
            if (distinct_left == '0) begin
              scan_cursor <= '0;
              out_valid   <= 1'b1;
            end else begin
              state     <= ST_SCAN;
              chk_valid <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          chk_valid <= 1'b1;
          if (found) begin
            state       <= ST_RUN;
            chk_valid   <= 1'b0;
            out_valid   <= 1'b1;
            scan_cursor <= found_last ? '0 : chk_addr + 1'b1;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    b_addr   <= head.code[CODE_BITS-1:0];
    fwd_addr <= mem_waddr;
    fwd_data <= mem_wdata;
    chk_addr <= scan_pos;
    if (pop_report) begin
      scan_pos <= scan_cursor;
    end else begin
      scan_pos <= scan_pos + 1'b1;
    end
    if (pop_report) begin
      out_code  <= '0;
      out_count <= '0;
      out_last  <= 1'b0;
      out_none  <= 1'b1;
    end else if (found) begin
      out_code  <= chk_addr;
      out_count <= rd_data;
      out_last  <= found_last;
      out_none  <= 1'b0;
    end
  end

  assign results.valid       = out_valid;
  assign results.entry_code  = ucs_pkg::CHAR_W'(out_code);
  assign results.entry_count = ucs_pkg::COUNT_W'(out_count);
  assign results.last_entry  = out_last;
  assign results.none_left   = out_none;

endmodule

`default_nettype wire

// ===== src/ucs2_character_histogram.sv =====
// Character code histogram with an ascending read-and-clear report.
//
// The items channel takes requests. With func at count, the bin of
// char_code (its low CODE_BITS bits) is incremented, saturating, and no
// result follows. With func at report, the next nonzero bin at or after
// the scan cursor, wrapping past the top bin, is returned on the results
// channel with its count and cleared; last_entry marks the final one,
// none_left an empty store. Count requests sustain one per cycle while
// no report waits or scans, through a two-stage read-modify-write of
// the count memory. A report waits for the count pipeline to drain and
// for the result register to be free, then scans the memory one bin per
// cycle up to the next nonzero bin; on an empty store it returns
// none_left without a scan. After reset a clearing pass writes every
// bin, and no request is taken until it ends. A stalled receiver holds
// the result register; counting goes on until a report reaches the head
// of the four-entry queue that decouples request intake from the memory
// side.
`default_nettype none

module ucs2_character_histogram #(
  parameter int CODE_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  ucs_in_if.sink    items,
  ucs_out_if.source results
);

  ucs_pkg::back_status_t status;
  ucs_pkg::op_t          push_data;
  ucs_pkg::op_t          head;
  logic                  push;
  logic                  pop;
  logic                  queue_full;
  logic                  not_empty;

  ucs_front #(
    .CODE_BITS (CODE_BITS)
  ) u_front (
    .items      (items),
    .status     (status),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  ucs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (not_empty),
    .head      (head)
  );

  ucs_back #(
    .CODE_BITS  (CODE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .status    (status),
    .results   (results)
  );

endmodule

`default_nettype wire
